// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the spectrum meter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPBM_ASSERT(LABEL, CLK, RSTN, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("spbm assertion failed");

// Next-cycle implication, disabled during reset.
`define SPBM_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("spbm assertion failed");

`endif

// File: src/spbm_pkg.sv
// ----------------------------------------------------------------------------
// spbm_pkg
// Shared types and constants of the spectrum bar meter.
// ----------------------------------------------------------------------------
package spbm_pkg;

    localparam int MAX_BANDS   = 256;
    localparam int BAND_W      = $clog2(MAX_BANDS);
    localparam int IDX_OUT_W   = 8;

    localparam int AMP_W       = 32;
    localparam int ACC_W       = 40;
    localparam int HEIGHT_W    = 10;
    localparam int GAIN_W      = 8;
    localparam int PROD_W      = 45;

    localparam int FRAC_W      = 16;
    localparam int QUOT_W      = 24;
    localparam int LOW_W       = QUOT_W - FRAC_W;
    localparam int HI_W        = PROD_W - LOW_W;
    localparam int X_W         = QUOT_W + 1;
    localparam int MANT_W      = 31;
    localparam int INT_W       = 4;
    localparam int L2_W        = INT_W + FRAC_W;
    localparam int K_W         = 32;
    localparam int LG_W        = L2_W;
    localparam int ZL_W        = HEIGHT_W + LG_W - FRAC_W;
    localparam int STEP_W      = $clog2(QUOT_W + 1);

    localparam logic [GAIN_W-1:0] GAIN_LN = 8'd30;
    localparam logic [GAIN_W-1:0] GAIN_LG = 8'd150;
    localparam logic [K_W-1:0]    LN2_Q32 = 32'd2977044472;
    localparam logic [K_W-1:0]    LG2_Q32 = 32'd1292913986;

    localparam logic [HEIGHT_W-1:0] HEIGHT_ALL_ONES = '1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_BAND_MODE      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALLOFF_ENABLE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_STEP      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 8'd3;

    typedef struct packed {
        logic                band_mode;
        logic                falloff_enable;
        logic [HEIGHT_W-1:0] fall_step;
        logic [HEIGHT_W-1:0] display_height;
    } cfg_t;

    typedef enum logic {
        JOB_BAND,
        JOB_CLEAR
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic               ln_mode;
        logic [ACC_W-1:0]   value;
        logic [AMP_W-1:0]   norm;
        logic [BAND_W-1:0]  idx;
        logic               last_frame;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIVINIT,
        ST_DIV,
        ST_LOG,
        ST_SQR,
        ST_SCL1,
        ST_SCL2,
        ST_CLAMP,
        ST_FALL
    } back_state_t;

endpackage

// File: src/spbm_front.sv
// ----------------------------------------------------------------------------
// spbm_front
// Input side: accepts bin words, sums bands, numbers bands, queues jobs.
// ----------------------------------------------------------------------------
module spbm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [spbm_pkg::AMP_W-1:0]    amplitude,
    input  logic [spbm_pkg::AMP_W-1:0]    frame_max,
    input  logic                          last_in_band,
    input  logic                          last_in_frame,
    input  logic                          band_mode,
    input  spbm_pkg::queue_status_t       q_status,
    output logic                          push,
    output spbm_pkg::job_t                push_job
);
    import spbm_pkg::*;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [BAND_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W:0]    sum_full;
    logic [ACC_W-1:0]  sum_sat;
    logic              accept;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign sum_full = {1'b0, acc_reg} + (ACC_W+1)'(amplitude);
    assign sum_sat  = sum_full[ACC_W] ? {ACC_W{1'b1}} : sum_full[ACC_W-1:0];

    always_comb
    begin
        acc_next            = acc_reg;
        cnt_next            = cnt_reg;
        push                = 1'b0;
        push_job.kind       = JOB_BAND;
        push_job.ln_mode    = band_mode;
        push_job.value      = band_mode ? sum_sat : ACC_W'(amplitude);
        push_job.norm       = frame_max;
        push_job.idx        = cnt_reg;
        push_job.last_frame = last_in_frame;
        if (accept)
        begin
            if (command)
            begin
                acc_next      = '0;
                cnt_next      = '0;
                push          = 1'b1;
                push_job.kind = JOB_CLEAR;
            end
            else if (frame_max != '0)
            begin
                if (band_mode && !last_in_band && !last_in_frame)
                begin
                    acc_next = sum_sat;
                end
                else
                begin
                    acc_next = '0;
                    push     = 1'b1;
                    if (last_in_frame)
                        cnt_next = '0;
                    else if (cnt_reg != BAND_W'(MAX_BANDS - 1))
                        cnt_next = cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: src/spbm_queue.sv
// ----------------------------------------------------------------------------
// spbm_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spbm_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  spbm_pkg::job_t          push_job,
    input  logic                    pop,
    output spbm_pkg::job_t          head,
    output spbm_pkg::queue_status_t status
);
    import spbm_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    `SPBM_ASSERT(a_no_overflow, clk, rst_n, push, !status.full)
    `SPBM_ASSERT(a_no_underflow, clk, rst_n, pop, !status.empty)
    `SPBM_ASSERT(a_count_range, clk, rst_n, 1'b1, count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))

endmodule

// File: src/spbm_back.sv
// ----------------------------------------------------------------------------
// spbm_back
// Job engine: ratio divide, log2 by squaring, scaling, falloff, height store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spbm_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spbm_pkg::cfg_t                  cfg,
    input  spbm_pkg::queue_status_t         q_status,
    input  spbm_pkg::job_t                  head,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [spbm_pkg::IDX_OUT_W-1:0]  band_index,
    output logic [spbm_pkg::HEIGHT_W-1:0]   bar_height,
    output logic                            last_band
);
    import spbm_pkg::*;

    back_state_t          state_reg, state_next;
    job_t                 job_reg, job_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [AMP_W-1:0]     rem_reg, rem_next;
    logic [QUOT_W-1:0]    bits_reg, bits_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [INT_W-1:0]     int_reg, int_next;
    logic [FRAC_W-1:0]    frac_reg, frac_next;
    logic [MANT_W-1:0]    mant_reg, mant_next;
    logic [LG_W-1:0]      lg_reg, lg_next;
    logic [ZL_W-1:0]      zl_reg, zl_next;
    logic [HEIGHT_W-1:0]  z_reg, z_next;
    logic [MAX_BANDS-1:0] valid_reg, valid_next;

    logic [HEIGHT_W-1:0]  height_mem [MAX_BANDS];
    logic [HEIGHT_W-1:0]  rd_data_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [IDX_OUT_W-1:0] band_index_reg;
    logic [HEIGHT_W-1:0]  bar_height_reg;
    logic                 last_band_reg;

    logic                 wr_en;
    logic                 clear_pop;
    logic [HEIGHT_W-1:0]  h_new;

    assign out_valid  = out_valid_reg;
    assign band_index = band_index_reg;
    assign bar_height = bar_height_reg;
    assign last_band  = last_band_reg;

    always_comb
    begin
        logic [GAIN_W-1:0]   gain;
        logic [HI_W-1:0]     hi;
        logic [AMP_W:0]      trial;
        logic [X_W-1:0]      x;
        logic [STEP_W-1:0]   top;
        logic [STEP_W-1:0]   sh;
        logic [2*MANT_W-1:0] sq;
        logic [AMP_W-1:0]    sq_hi;
        logic [K_W-1:0]      k;
        logic [L2_W+K_W-1:0] lp;
        logic [HEIGHT_W+LG_W-1:0] hp;
        logic [HEIGHT_W-1:0] hm1;
        logic [HEIGHT_W-1:0] h_old;
        logic [HEIGHT_W-1:0] dec;

        state_next = state_reg;
        job_next   = job_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        bits_next  = bits_reg;
        quot_next  = quot_reg;
        step_next  = step_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        mant_next  = mant_reg;
        lg_next    = lg_reg;
        zl_next    = zl_reg;
        z_next     = z_reg;
        valid_next = valid_reg;
        pop        = 1'b0;
        clear_pop  = 1'b0;
        wr_en      = 1'b0;
        h_new      = z_reg;
        out_valid_next = out_valid_reg && out_stall;

        gain  = job_reg.ln_mode ? GAIN_LN : GAIN_LG;
        hi    = prod_reg[PROD_W-1:LOW_W];
        trial = {rem_reg, bits_reg[QUOT_W-1]};
        x     = X_W'(quot_reg) + X_W'(2 ** FRAC_W);
        top   = STEP_W'(FRAC_W);
        for (int i = FRAC_W; i < X_W; i++)
        begin
            if (x[i])
                top = STEP_W'(i);
        end
        sh    = STEP_W'(MANT_W - 1) - top;
        sq    = {{MANT_W{1'b0}}, mant_reg} * {{MANT_W{1'b0}}, mant_reg};
        sq_hi = sq[2*MANT_W-1:MANT_W-1];
        k     = job_reg.ln_mode ? LN2_Q32 : LG2_Q32;
        lp    = {{K_W{1'b0}}, int_reg, frac_reg} * {{L2_W{1'b0}}, k};
        hp    = {{LG_W{1'b0}}, cfg.display_height} * {{HEIGHT_W{1'b0}}, lg_reg};
        hm1   = cfg.display_height - 1'b1;
        h_old = valid_reg[job_reg.idx] ? rd_data_reg : '0;
        dec   = h_old - cfg.fall_step;

        if (cfg.falloff_enable && (h_old > cfg.fall_step))
            h_new = (z_reg > dec) ? z_reg : dec;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    if (head.kind == JOB_CLEAR)
                    begin
                        clear_pop  = 1'b1;
                        valid_next = '0;
                    end
                    else
                    begin
                        job_next   = head;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'({{GAIN_W{1'b0}}, job_reg.value}
                                     * {{ACC_W{1'b0}}, gain});
                state_next = ST_DIVINIT;
            end
            ST_DIVINIT:
            begin
                if (hi >= HI_W'(job_reg.norm))
                begin
                    quot_next  = '1;
                    state_next = ST_LOG;
                end
                else
                begin
                    rem_next   = hi[AMP_W-1:0];
                    bits_next  = {prod_reg[LOW_W-1:0], {FRAC_W{1'b0}}};
                    quot_next  = '0;
                    step_next  = STEP_W'(QUOT_W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, job_reg.norm})
                begin
                    rem_next  = AMP_W'(trial - {1'b0, job_reg.norm});
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[AMP_W-1:0];
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
                end
                bits_next = {bits_reg[QUOT_W-2:0], 1'b0};
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                    state_next = ST_LOG;
            end
            ST_LOG:
            begin
                mant_next  = MANT_W'({{(MANT_W-X_W){1'b0}}, x} << sh);
                int_next   = INT_W'(top - STEP_W'(FRAC_W));
                frac_next  = '0;
                step_next  = STEP_W'(FRAC_W);
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                if (sq_hi[AMP_W-1])
                    mant_next = sq_hi[AMP_W-1:1];
                else
                    mant_next = sq_hi[MANT_W-1:0];
                frac_next = {frac_reg[FRAC_W-2:0], sq_hi[AMP_W-1]};
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                    state_next = ST_SCL1;
            end
            ST_SCL1:
            begin
                lg_next    = lp[L2_W+K_W-1:K_W];
                state_next = ST_SCL2;
            end
            ST_SCL2:
            begin
                zl_next    = hp[HEIGHT_W+LG_W-1:FRAC_W];
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (cfg.display_height == '0)
                    z_next = '0;
                else if (zl_reg > ZL_W'(hm1))
                    z_next = hm1;
                else
                    z_next = zl_reg[HEIGHT_W-1:0];
                state_next = ST_FALL;
            end
            ST_FALL:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    wr_en                   = 1'b1;
                    valid_next[job_reg.idx] = 1'b1;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
        step_reg <= step_next;
        int_reg  <= int_next;
        frac_reg <= frac_next;
        mant_reg <= mant_next;
        lg_reg   <= lg_next;
        zl_reg   <= zl_next;
        z_reg    <= z_next;
        if (wr_en)
        begin
            band_index_reg <= IDX_OUT_W'(job_reg.idx);
            bar_height_reg <= h_new;
            last_band_reg  <= job_reg.last_frame;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            height_mem[job_reg.idx] <= h_new;
        rd_data_reg <= height_mem[job_reg.idx];
    end

    `SPBM_ASSERT(a_mant_norm, clk, rst_n, state_reg == ST_SQR, mant_reg[MANT_W-1])
    `SPBM_ASSERT_NEXT(a_clear_all, clk, rst_n, clear_pop, valid_reg == '0)
    `SPBM_ASSERT(a_height_range, clk, rst_n, out_valid_reg, bar_height_reg != HEIGHT_ALL_ONES)

endmodule

// File: src/spectrum_bar_meter_with_falloff.sv
// ----------------------------------------------------------------------------
// spectrum_bar_meter_with_falloff
// Log-scaled spectrum bar meter with per-band peak falloff.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   command, amplitude, frame_max,
//                                             last_in_band, last_in_frame
//   out      source     out_valid / out_stall band_index, bar_height, last_band
//   cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Front takes one word per cycle while the queue is not full (in_stall low).
// Each band result holds the back engine through restoring division of a
// 24-bit quotient (skipped on a saturated ratio), 16 log2 squaring steps,
// then scaling. A 4-deep job queue couples front and back.
// Reset: config to defaults; stored heights read as zero via valid flags.
// out_stall holds only the final height update; in_stall = queue full.
// ----------------------------------------------------------------------------
module spectrum_bar_meter_with_falloff (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic [spbm_pkg::AMP_W-1:0]        amplitude,
    input  logic [spbm_pkg::AMP_W-1:0]        frame_max,
    input  logic                              last_in_band,
    input  logic                              last_in_frame,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [spbm_pkg::IDX_OUT_W-1:0]    band_index,
    output logic [spbm_pkg::HEIGHT_W-1:0]     bar_height,
    output logic                              last_band,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spbm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import spbm_pkg::*;

    cfg_t          cfg_reg, cfg_next;
    logic          push;
    logic          pop;
    job_t          push_job;
    job_t          head;
    queue_status_t q_status;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BAND_MODE:      cfg_next.band_mode      = cfg_data[0];
                REG_FALLOFF_ENABLE: cfg_next.falloff_enable = cfg_data[0];
                REG_FALL_STEP:      cfg_next.fall_step      = cfg_data[HEIGHT_W-1:0];
                REG_DISPLAY_HEIGHT: cfg_next.display_height = cfg_data[HEIGHT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_mode      <= 1'b1;
            cfg_reg.falloff_enable <= 1'b1;
            cfg_reg.fall_step      <= HEIGHT_W'(1);
            cfg_reg.display_height <= HEIGHT_W'(64);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    spbm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .amplitude     (amplitude),
        .frame_max     (frame_max),
        .last_in_band  (last_in_band),
        .last_in_frame (last_in_frame),
        .band_mode     (cfg_reg.band_mode),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    spbm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    spbm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_status   (q_status),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .band_index (band_index),
        .bar_height (bar_height),
        .last_band  (last_band)
    );

endmodule
